@@ src/apid_pkg.sv @@
// Shared widths, register codes, state and control types for the attitude PID block.
package apid_pkg;

	localparam int ANGLE_W    = 9;
	localparam int GAIN_W     = 16;
	localparam int EDB_W      = 8;
	localparam int RDB_W      = 23;
	localparam int GYRO_W     = 16;
	localparam int ACT_W      = 32;
	localparam int DIR_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;
	localparam int ERR_W      = 9;
	localparam int EMAG_W     = 8;
	localparam int RATE_W     = 27;
	localparam int RMAG_W     = 26;
	localparam int INC_MAG_W  = 22;
	localparam int SUM_W      = 32;
	localparam int ACC_W      = 50;
	localparam int FRAC_BITS  = 8;

	localparam int HALF_TURN  = 180;
	localparam int FULL_TURN  = 360;
	localparam int MS_PER_S   = 1000;
	localparam int FRAC_SCALE = 256;
	localparam int RATE_SCALE = 256000;

	localparam logic [RDB_W-1:0] DETUMBLE_RST = 23'h7FFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET,
		REG_KP,
		REG_KI,
		REG_KD,
		REG_EDB,
		REG_RDB,
		REG_DETUMBLE,
		REG_USE_GYRO
	} cfg_reg_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_STOP,
		DIR_CW,
		DIR_CCW
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SUM,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

endpackage

@@ src/apid_if.sv @@
// Valid/ready channel interfaces for the sample and result beats.
interface apid_in_if import apid_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [ANGLE_W-1:0]       current_angle;
	logic signed [GYRO_W-1:0] gyro_rate;

	modport source (output valid, output current_angle, output gyro_rate, input ready);
	modport sink (input valid, input current_angle, input gyro_rate, output ready);
endinterface

interface apid_out_if import apid_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ACT_W-1:0] actuation;
	logic [DIR_W-1:0]        direction;

	modport source (output valid, output actuation, output direction, input ready);
	modport sink (input valid, input actuation, input direction, output ready);
endinterface

@@ src/apid_sdiv.sv @@
// Bit-serial restoring divider by a fixed divisor, one quotient bit per step.
module apid_sdiv import apid_pkg::*; #(
	parameter int DW      = 26,
	parameter int DIVISOR = 1000
) (
	input  logic          clk,
	input  div_ctrl_t     ctrl,
	input  logic [DW-1:0] dividend,
	output logic [DW-1:0] quotient
);

	localparam int RW = $clog2(DIVISOR + 1) + 1;

	logic [DW-1:0] num_q;
	logic [RW-2:0] rem_q;
	logic [RW-1:0] trial;
	logic          ge;

	assign trial = {rem_q, num_q[DW-1]};
	assign ge    = trial >= RW'(DIVISOR);

	// dividend shifts out at the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (ctrl.step) begin
			rem_q <= ge ? (RW-1)'(trial - RW'(DIVISOR)) : trial[RW-2:0];
			num_q <= {num_q[DW-2:0], ge};
		end
	end

	assign quotient = num_q;

endmodule

@@ src/attitude_pid_with_deadband.sv @@
// Top level of the attitude PID controller with error and rate deadbands.
//
// sample carries one beat per control tick: current_angle (degrees) and
// gyro_rate (degrees/s). result returns one beat per sample: actuation
// (signed Q.8, saturated) and direction (stop, clockwise, counterclockwise).
// Gains, target, deadbands, detumble threshold and rate source are written by the
// user through wr_en / wr_index / wr_data only while the block is idle; the block does not enforce this.
//
// One sample at a time: a beat is taken in the idle state, then two
// bit-serial dividers run DW steps (rate over the period, integral step over
// one second), the SUM state updates the integral, and a radix-2 multiplier
// walks the 16 gain bits for all three terms at once. The DONE state then
// loads the result into the output register and returns to idle, where the
// next sample can be taken (DW = 26 at PERIOD_MS = 1000).
// The output register lets the next sample be taken while a result waits;
// if the receiver still holds the previous one, the block waits in its last
// state. Reset clears the integral, the last error and the output valid flag,
// and returns the configuration to zero (detumble threshold to all ones).
module attitude_pid_with_deadband import apid_pkg::*; #(
	parameter int PERIOD_MS = 1000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	apid_in_if.sink               sample,
	apid_out_if.source            result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam longint INC_MAX = 64'(HALF_TURN) * FRAC_SCALE * PERIOD_MS;
	localparam int     INW     = $clog2(INC_MAX + 1);
	localparam int     DW      = INW > RMAG_W ? INW : RMAG_W;
	localparam int     CW      = $clog2(DW);

	// configuration
	logic [ANGLE_W-1:0]       target_q;
	logic signed [GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [EDB_W-1:0]         edb_q;
	logic [RDB_W-1:0]         rdb_q, thr_q;
	logic                     use_gyro_q;

	// loop state
	logic signed [ERR_W-1:0]  last_err_q;
	logic signed [SUM_W-1:0]  error_sum_q;

	// per-sample working registers
	state_t                   state_q, state_d;
	logic [CW-1:0]            cnt_q;
	logic signed [ERR_W-1:0]  err_q;
	logic [EMAG_W-1:0]        emag_q;
	logic                     eneg_q, dneg_q;
	logic signed [GYRO_W-1:0] gyro_q;
	logic                     dead_q;
	logic signed [ACC_W-1:0]  mp_q, mi_q, mr_q, acc_q;

	// output register
	logic                     out_valid_q;
	logic signed [ACT_W-1:0]  act_q;
	logic [DIR_W-1:0]         dir_q;

	logic                     accept, out_load;
	div_ctrl_t                div_ctrl;

	// ---------------- error and error change at the sample beat
	logic signed [ANGLE_W+1:0] ang_diff, err_w;
	logic signed [ERR_W-1:0]   err_c;
	logic signed [ERR_W:0]     chg_raw, chg_w;
	logic signed [ERR_W-1:0]   chg_c;
	logic [EMAG_W-1:0]         emag_c, dmag_c;
	logic [DW-1:0]             rnum_c, inum_c;

	assign ang_diff = $signed({2'b00, target_q}) - $signed({2'b00, sample.current_angle});

	// one step of 360 is enough for inputs of 9 bits
	always_comb begin
		err_w = ang_diff;
		if (ang_diff > (ANGLE_W+2)'(HALF_TURN))
			err_w = ang_diff - (ANGLE_W+2)'(FULL_TURN);
		else if (ang_diff < -(ANGLE_W+2)'(HALF_TURN))
			err_w = ang_diff + (ANGLE_W+2)'(FULL_TURN);
	end

	assign err_c   = err_w[ERR_W-1:0];
	assign chg_raw = {err_c[ERR_W-1], err_c} - {last_err_q[ERR_W-1], last_err_q};

	always_comb begin
		chg_w = chg_raw;
		if (chg_raw > (ERR_W+1)'(HALF_TURN))
			chg_w = chg_raw - (ERR_W+1)'(FULL_TURN);
		else if (chg_raw < -(ERR_W+1)'(HALF_TURN))
			chg_w = chg_raw + (ERR_W+1)'(FULL_TURN);
	end

	assign chg_c  = chg_w[ERR_W-1:0];
	assign emag_c = err_c[ERR_W-1] ? EMAG_W'(-err_c) : err_c[EMAG_W-1:0];
	assign dmag_c = chg_c[ERR_W-1] ? EMAG_W'(-chg_c) : chg_c[EMAG_W-1:0];
	assign rnum_c = DW'(dmag_c) * DW'(RATE_SCALE);
	assign inum_c = DW'(emag_c) * DW'(64'(FRAC_SCALE) * PERIOD_MS);

	// ---------------- dividers
	logic [DW-1:0] rate_quo, inc_quo;

	apid_sdiv #(
		.DW      (DW),
		.DIVISOR (PERIOD_MS)
	) u_rate_div (
		.clk      (clk),
		.ctrl     (div_ctrl),
		.dividend (rnum_c),
		.quotient (rate_quo)
	);

	apid_sdiv #(
		.DW      (DW),
		.DIVISOR (MS_PER_S)
	) u_inc_div (
		.clk      (clk),
		.ctrl     (div_ctrl),
		.dividend (inum_c),
		.quotient (inc_quo)
	);

	// ---------------- rate, integral and mode after the divide
	logic signed [RATE_W-1:0]    rate_div, rate_gy, rate_c;
	logic [RMAG_W-1:0]           rate_abs;
	logic signed [INC_MAG_W:0]   inc_c;
	logic signed [SUM_W+1:0]     sum_wide;
	logic signed [SUM_W-1:0]     sum_sat;
	logic                        dead_c, det_c;

	assign rate_div = dneg_q ? -$signed({1'b0, rate_quo[RMAG_W-1:0]})
	                         :  $signed({1'b0, rate_quo[RMAG_W-1:0]});
	assign rate_gy  = $signed({{(RATE_W-GYRO_W-FRAC_BITS){gyro_q[GYRO_W-1]}}, gyro_q,
	                           FRAC_BITS'(0)});
	assign rate_c   = use_gyro_q ? rate_gy : rate_div;
	assign rate_abs = rate_c[RATE_W-1] ? RMAG_W'(-rate_c) : rate_c[RMAG_W-1:0];

	assign inc_c    = eneg_q ? -$signed({1'b0, inc_quo[INC_MAG_W-1:0]})
	                         :  $signed({1'b0, inc_quo[INC_MAG_W-1:0]});
	assign sum_wide = (SUM_W+2)'(error_sum_q) + (SUM_W+2)'(inc_c);

	always_comb begin
		if (sum_wide[SUM_W+1:SUM_W-1] == '0 || sum_wide[SUM_W+1:SUM_W-1] == '1)
			sum_sat = sum_wide[SUM_W-1:0];
		else
			sum_sat = sum_wide[SUM_W+1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
	end

	assign dead_c = (emag_q < edb_q) && (rate_abs < RMAG_W'(rdb_q));
	assign det_c  = rate_abs > RMAG_W'(thr_q);

	// ---------------- serial multiply, gain bits MSB first
	logic [3:0]              bit_idx;
	logic signed [ACC_W-1:0] addend;
	logic                    top_bit;

	assign bit_idx = cnt_q[3:0];
	assign top_bit = bit_idx == 4'(GAIN_W-1);
	assign addend  = (kp_q[bit_idx] ? mp_q : '0) + (ki_q[bit_idx] ? mi_q : '0)
	               + (kd_q[bit_idx] ? mr_q : '0);

	// ---------------- final shift and saturation
	logic signed [ACC_W-1:0] shifted;
	logic signed [ACT_W-1:0] act_sat, act_c;

	assign shifted = acc_q >>> FRAC_BITS;

	always_comb begin
		if (shifted[ACC_W-1:ACT_W-1] == '0 || shifted[ACC_W-1:ACT_W-1] == '1)
			act_sat = shifted[ACT_W-1:0];
		else
			act_sat = shifted[ACC_W-1] ? {1'b1, {(ACT_W-1){1'b0}}} : {1'b0, {(ACT_W-1){1'b1}}};
	end

	assign act_c = dead_q ? '0 : act_sat;

	// ---------------- control
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (sample.valid) state_d = ST_DIV;
			ST_DIV:  if (cnt_q == '0) state_d = ST_SUM;
			ST_SUM:  state_d = ST_MUL;
			ST_MUL:  if (cnt_q == '0) state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || result.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample.ready  = 1'b0;
		div_ctrl.load = 1'b0;
		div_ctrl.step = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample.ready  = 1'b1;
				div_ctrl.load = sample.valid;
			end
			ST_DIV:  div_ctrl.step = 1'b1;
			ST_DONE: out_load      = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	assign accept = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				cnt_q <= CW'(DW - 1);
			else if (state_q == ST_SUM)
				cnt_q <= CW'(GAIN_W - 1);
			else if ((state_q == ST_DIV || state_q == ST_MUL) && cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			kp_q       <= '0;
			ki_q       <= '0;
			kd_q       <= '0;
			edb_q      <= '0;
			rdb_q      <= '0;
			thr_q      <= DETUMBLE_RST;
			use_gyro_q <= 1'b0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_TARGET:   target_q   <= wr_data[ANGLE_W-1:0];
				REG_KP:       kp_q       <= wr_data[GAIN_W-1:0];
				REG_KI:       ki_q       <= wr_data[GAIN_W-1:0];
				REG_KD:       kd_q       <= wr_data[GAIN_W-1:0];
				REG_EDB:      edb_q      <= wr_data[EDB_W-1:0];
				REG_RDB:      rdb_q      <= wr_data[RDB_W-1:0];
				REG_DETUMBLE: thr_q      <= wr_data[RDB_W-1:0];
				REG_USE_GYRO: use_gyro_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q  <= '0;
			error_sum_q <= '0;
		end else begin
			if (accept)
				last_err_q <= err_c;
			if (state_q == ST_SUM)
				error_sum_q <= sum_sat;
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q  <= err_c;
			emag_q <= emag_c;
			eneg_q <= err_c[ERR_W-1];
			dneg_q <= chg_c[ERR_W-1];
			gyro_q <= sample.gyro_rate;
		end
		if (state_q == ST_SUM) begin
			dead_q <= dead_c;
			// above the detumble threshold only the rate term survives
			mp_q   <= det_c ? '0 : ACC_W'($signed({err_q, FRAC_BITS'(0)}));
			mi_q   <= det_c ? '0 : ACC_W'(sum_sat);
			mr_q   <= ACC_W'(rate_c);
			acc_q  <= '0;
		end
		if (state_q == ST_MUL)
			acc_q <= (acc_q <<< 1) + (top_bit ? -addend : addend);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			act_q <= act_c;
			if (act_c > 0)
				dir_q <= DIR_CW;
			else if (act_c < 0)
				dir_q <= DIR_CCW;
			else
				dir_q <= DIR_STOP;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.actuation = act_q;
	assign result.direction = dir_q;

endmodule

@@ test/tb_attitude_pid_with_deadband.sv @@
// Self-checking testbench for the attitude PID controller with deadbands.
`timescale 1ns / 100ps

module tb_attitude_pid_with_deadband;
	import apid_pkg::*;

	localparam int PERIOD_MS = 1000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES = 600;

	typedef struct {
		logic [ANGLE_W-1:0]       angle;
		logic signed [GYRO_W-1:0] gyro;
	} tick_t;

	typedef struct {
		logic signed [ACT_W-1:0] act;
		dir_t                    dir;
	} drive_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	apid_in_if  sample_ch ();
	apid_out_if result_ch ();

	attitude_pid_with_deadband #(.PERIOD_MS(PERIOD_MS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// controller copy: registers and loop state
	logic [ANGLE_W-1:0]       cfg_target;
	logic signed [GAIN_W-1:0] cfg_kp;
	logic signed [GAIN_W-1:0] cfg_ki;
	logic signed [GAIN_W-1:0] cfg_kd;
	logic [EDB_W-1:0]         cfg_edb;
	logic [RDB_W-1:0]         cfg_rdb;
	logic [RDB_W-1:0]         cfg_thr;
	logic                     cfg_gyro;
	int                       prev_err;
	longint                   integ_q8;

	tick_t  pending_ticks[$];
	drive_t drive_due[$];
	logic   in_taken;
	logic   calm;
	int     hold_asked;
	int     hold_begun;
	int     hold_cnt;
	int     errors;

	always #4 clk = ~clk;

	function automatic int wrap_deg(int d);
		while (d > HALF_TURN) d -= FULL_TURN;
		while (d < -HALF_TURN) d += FULL_TURN;
		return d;
	endfunction

	function automatic longint clip32(longint v);
		if (v > longint'(32'sh7FFFFFFF)) return longint'(32'sh7FFFFFFF);
		if (v < -longint'(32'sh7FFFFFFF) - 1) return -longint'(32'sh7FFFFFFF) - 1;
		return v;
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// one control tick: advances error history and integral, returns the drive
	function automatic drive_t predict_drive(logic [ANGLE_W-1:0] angle,
			logic signed [GYRO_W-1:0] gyro);
		int     err;
		longint rate;
		longint total;
		drive_t d;
		err = wrap_deg(int'(cfg_target) - int'(angle));
		if (cfg_gyro)
			rate = longint'(gyro) * FRAC_SCALE;
		else
			rate = longint'(wrap_deg(err - prev_err)) * RATE_SCALE / PERIOD_MS;
		prev_err = err;
		integ_q8 = clip32(integ_q8 + longint'(err) * FRAC_SCALE * PERIOD_MS / MS_PER_S);
		if (mag(longint'(err)) < longint'(cfg_edb) && mag(rate) < longint'(cfg_rdb))
			total = 0;
		else if (mag(rate) > longint'(cfg_thr))
			total = longint'(cfg_kd) * rate;
		else
			total = longint'(cfg_kp) * err * FRAC_SCALE + longint'(cfg_ki) * integ_q8
				+ longint'(cfg_kd) * rate;
		// arithmetic shift floors, as the block does
		d.act = 32'(clip32(total >>> FRAC_BITS));
		d.dir = (d.act > 0) ? DIR_CW : ((d.act < 0) ? DIR_CCW : DIR_STOP);
		return d;
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	// driver: new beat offered at the falling edge
	always @(negedge clk) begin
		tick_t nxt;
		if (arst_n && (!sample_ch.valid || in_taken)) begin
			if (pending_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
				nxt = pending_ticks.pop_front();
				sample_ch.valid <= 1'b1;
				sample_ch.current_angle <= nxt.angle;
				sample_ch.gyro_rate <= nxt.gyro;
			end else begin
				sample_ch.valid <= 1'b0;
				sample_ch.current_angle <= 9'($urandom);
				sample_ch.gyro_rate <= 16'($urandom);
			end
		end
	end

	// receiver ready, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_asked != hold_begun) begin
			hold_begun = hold_asked;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= calm || ($urandom_range(0, 99) >= 10);
		end
	end

	// monitor: predict on each accepted sample beat, check each result beat
	always @(posedge clk) begin
		drive_t want;
		if (arst_n) begin
			in_taken = sample_ch.valid && sample_ch.ready;
			if (in_taken)
				drive_due.push_back(predict_drive(sample_ch.current_angle, sample_ch.gyro_rate));
			if (result_ch.valid && result_ch.ready) begin
				if (drive_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat, actuation %0d direction %0d",
						$time, result_ch.actuation, result_ch.direction);
				end else begin
					want = drive_due.pop_front();
					if (result_ch.actuation !== want.act) begin
						errors++;
						$display("%0t: actuation mismatch, expected %0d, got %0d",
							$time, want.act, result_ch.actuation);
					end
					if (result_ch.direction !== want.dir) begin
						errors++;
						$display("%0t: direction mismatch, expected %0d, got %0d",
							$time, want.dir, result_ch.direction);
					end
				end
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_TARGET:   cfg_target = val[ANGLE_W-1:0];
			REG_KP:       cfg_kp = val[GAIN_W-1:0];
			REG_KI:       cfg_ki = val[GAIN_W-1:0];
			REG_KD:       cfg_kd = val[GAIN_W-1:0];
			REG_EDB:      cfg_edb = val[EDB_W-1:0];
			REG_RDB:      cfg_rdb = val[RDB_W-1:0];
			REG_DETUMBLE: cfg_thr = val[RDB_W-1:0];
			REG_USE_GYRO: cfg_gyro = val[0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic load_all(input logic [ANGLE_W-1:0] target, input logic [GAIN_W-1:0] kp,
			input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd,
			input logic [EDB_W-1:0] edb, input logic [RDB_W-1:0] rdb,
			input logic [RDB_W-1:0] thr, input logic gyro_sel);
		write_reg(REG_TARGET, CFG_DATA_W'(target));
		write_reg(REG_KP, CFG_DATA_W'(kp));
		write_reg(REG_KI, CFG_DATA_W'(ki));
		write_reg(REG_KD, CFG_DATA_W'(kd));
		write_reg(REG_EDB, CFG_DATA_W'(edb));
		write_reg(REG_RDB, rdb);
		write_reg(REG_DETUMBLE, thr);
		write_reg(REG_USE_GYRO, CFG_DATA_W'(gyro_sel));
	endtask

	task automatic add_tick(input int angle, input int gyro);
		tick_t t;
		t.angle = ANGLE_W'(angle);
		t.gyro = GYRO_W'(gyro);
		pending_ticks.push_back(t);
	endtask

	task automatic wait_drained();
		while (pending_ticks.size() != 0 || (sample_ch.valid && !in_taken)
				|| drive_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int ang;
		int gyr;
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.current_angle = '0;
		sample_ch.gyro_rate = '0;
		result_ch.ready = 1'b0;
		in_taken = 1'b0;
		calm = 1'b0;
		hold_asked = 0;
		hold_begun = 0;
		hold_cnt = 0;
		errors = 0;
		cfg_target = '0;
		cfg_kp = '0;
		cfg_ki = '0;
		cfg_kd = '0;
		cfg_edb = '0;
		cfg_rdb = '0;
		cfg_thr = DETUMBLE_RST;
		cfg_gyro = 1'b0;
		prev_err = 0;
		integ_q8 = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: zero gains, state still advances
		add_tick(0, 0);
		add_tick(359, 32767);
		add_tick(511, -32768);
		wait_drained();

		// wrap boundary, out-of-range angles, error-change rate
		load_all(0, 16'h0100, 16'h0010, 16'h0080, 0, 0, DETUMBLE_RST, 1'b0);
		add_tick(180, 0);
		add_tick(0, 0);
		add_tick(359, 0);
		add_tick(511, 0);
		add_tick(256, 32767);
		add_tick(400, -32768);
		wait_drained();

		// extreme gains, target at top of range
		load_all(180, 16'h8000, 16'h7FFF, 16'h8000, 0, 0, DETUMBLE_RST, 1'b0);
		add_tick(0, 0);
		add_tick(360, 0);
		add_tick(359, 0);
		wait_drained();
		write_reg(REG_TARGET, CFG_DATA_W'(511));
		add_tick(0, 0);
		add_tick(511, 0);
		wait_drained();

		// gyro path: only the negative full-scale rate exceeds the largest detumble threshold
		load_all(90, 16'h0200, 16'h0001, 16'h7FFF, 0, 0, DETUMBLE_RST, 1'b1);
		add_tick(90, -32768);
		add_tick(90, 32767);
		add_tick(100, -1);
		wait_drained();

		// deadband and detumble edges, strict compares on both sides
		load_all(90, 16'h0100, 16'h0000, 16'h0100, 10, 2560, 2560, 1'b1);
		add_tick(99, 9);
		add_tick(100, 9);
		add_tick(99, 10);
		add_tick(81, -11);
		wait_drained();
		write_reg(REG_EDB, CFG_DATA_W'(255));
		write_reg(REG_RDB, 23'h7FFFFF);
		add_tick(270, -10);
		add_tick(90, 0);
		wait_drained();

		// integral wind-up with no idling: drive saturates high
		calm = 1'b1;
		load_all(0, 16'h0100, 16'h7FFF, 16'h0000, 0, 0, DETUMBLE_RST, 1'b1);
		repeat (500) add_tick($urandom_range(190, 200), 0);
		wait_drained();
		calm = 1'b0;

		for (int ph = 0; ph < 6; ph++) begin
			load_all(($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359)),
				rand_gain(), rand_gain(), rand_gain(),
				($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30)),
				($urandom_range(0, 5) == 0) ? 23'h7FFFFF : 23'($urandom_range(0, 8000)),
				($urandom_range(0, 3) == 0) ? 23'($urandom_range(0, 8000)) :
					(($urandom_range(0, 2) == 0) ? 23'($urandom) : DETUMBLE_RST),
				ph[0]);
			for (int k = 0; k < 250; k++) begin
				if ($urandom_range(0, 3) == 0)
					ang = $urandom_range(0, 511);
				else
					ang = (int'(cfg_target) + $urandom_range(0, 60) + 330) % FULL_TURN;
				if ($urandom_range(0, 9) < 3)
					gyr = int'($urandom_range(0, 65535)) - 32768;
				else
					gyr = int'($urandom_range(0, 40)) - 20;
				add_tick(ang, gyr);
			end
			// back-pressure: receiver holds off while samples keep coming
			if (ph == 2)
				hold_asked++;
			wait_drained();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ attitude_pid_with_deadband.f @@
src/apid_pkg.sv
src/apid_if.sv
src/apid_sdiv.sv
src/attitude_pid_with_deadband.sv
test/tb_attitude_pid_with_deadband.sv
